// ===== sv/psc_pkg.sv =====
// Shared types, constants and command codes of the photon sphere crossing scorer.
`default_nettype none
package psc_pkg;

	localparam logic [62:0] SUM_MAX    = {63{1'b1}};
	localparam logic [14:0] ANGLE_MAX  = 15'd23040;
	localparam int          CORDIC_STEPS = 23;

	// multiplier operand select
	localparam logic [2:0] MS_EDEP = 3'd0;
	localparam logic [2:0] MS_XX   = 3'd1;
	localparam logic [2:0] MS_YY   = 3'd2;
	localparam logic [2:0] MS_ZZ   = 3'd3;
	localparam logic [2:0] MS_XU   = 3'd4;
	localparam logic [2:0] MS_YU   = 3'd5;
	localparam logic [2:0] MS_ZU   = 3'd6;
	localparam logic [2:0] MS_CC   = 3'd7;

	// accumulate operation
	localparam logic [1:0] ACC_NONE = 2'd0;
	localparam logic [1:0] ACC_SUMS = 2'd1;
	localparam logic [1:0] ACC_SQ   = 2'd2;
	localparam logic [1:0] ACC_DOT  = 2'd3;

	// angle source for the output word
	localparam logic [1:0] ANG_ZERO = 2'd0;
	localparam logic [1:0] ANG_90   = 2'd1;
	localparam logic [1:0] ANG_COR  = 2'd2;

	typedef struct packed {
		logic       load;
		logic [2:0] mul_sel;
		logic [1:0] acc_op;
		logic       sqrt_init_sq;
		logic       sqrt_init_sin;
		logic       sqrt_step;
		logic       r_latch;
		logic       div_init;
		logic       div_step;
		logic       cor_init;
		logic       cor_step;
		logic [4:0] cor_idx;
		logic       out_load;
		logic [1:0] ang_sel;
	} cmd_t;

	typedef struct packed {
		logic photon;
		logic r_zero;
		logic dot_nonpos;
		logic c_ge_one;
	} stat_t;

	// atan(2^-i) in degrees, Q.16, rounded to nearest
	function automatic logic signed [31:0] atan_deg(input logic [4:0] idx);
		logic signed [31:0] v;
		case (idx)
			5'd0:  v = 32'sd2949120;
			5'd1:  v = 32'sd1740967;
			5'd2:  v = 32'sd919879;
			5'd3:  v = 32'sd466945;
			5'd4:  v = 32'sd234379;
			5'd5:  v = 32'sd117304;
			5'd6:  v = 32'sd58666;
			5'd7:  v = 32'sd29335;
			5'd8:  v = 32'sd14668;
			5'd9:  v = 32'sd7334;
			5'd10: v = 32'sd3667;
			5'd11: v = 32'sd1833;
			5'd12: v = 32'sd917;
			5'd13: v = 32'sd458;
			5'd14: v = 32'sd229;
			5'd15: v = 32'sd115;
			5'd16: v = 32'sd57;
			5'd17: v = 32'sd29;
			5'd18: v = 32'sd14;
			5'd19: v = 32'sd7;
			5'd20: v = 32'sd4;
			5'd21: v = 32'sd2;
			5'd22: v = 32'sd1;
			default: v = 32'sd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== sv/psc_ctrl.sv =====
// Sequencer state machine of the photon sphere crossing scorer.
`default_nettype none
module psc_ctrl
	import psc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  wire logic  out_stall,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_EDEP = 5'd1;
	localparam logic [4:0] S_SUM  = 5'd2;
	localparam logic [4:0] S_M1   = 5'd3;
	localparam logic [4:0] S_M2   = 5'd4;
	localparam logic [4:0] S_M3   = 5'd5;
	localparam logic [4:0] S_M4   = 5'd6;
	localparam logic [4:0] S_M5   = 5'd7;
	localparam logic [4:0] S_M6   = 5'd8;
	localparam logic [4:0] S_SQ1  = 5'd9;
	localparam logic [4:0] S_DIVI = 5'd10;
	localparam logic [4:0] S_DIV  = 5'd11;
	localparam logic [4:0] S_CC   = 5'd12;
	localparam logic [4:0] S_SINI = 5'd13;
	localparam logic [4:0] S_SQ2  = 5'd14;
	localparam logic [4:0] S_CORI = 5'd15;
	localparam logic [4:0] S_COR  = 5'd16;
	localparam logic [4:0] S_OUT  = 5'd17;

	localparam logic [5:0] SQRT_LAST = 6'd31;
	localparam logic [5:0] DIV_LAST  = 6'd33;
	localparam logic [5:0] COR_LAST  = 6'(CORDIC_STEPS - 1);

	logic [4:0] state_q, state_d;
	logic [5:0] cnt_q, cnt_d;
	logic [1:0] ang_sel_q, ang_sel_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		cnt_d     = cnt_q;
		ang_sel_d = ang_sel_q;
		cmd.mul_sel = MS_EDEP;
		cmd.acc_op  = ACC_NONE;
		cmd.ang_sel = ang_sel_q;
		cmd.cor_idx = cnt_q[4:0];
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					ang_sel_d = ANG_ZERO;
					state_d   = S_EDEP;
				end
			end
			S_EDEP: begin
				cmd.mul_sel = MS_EDEP;
				state_d     = S_SUM;
			end
			S_SUM: begin
				cmd.acc_op  = ACC_SUMS;
				cmd.mul_sel = MS_XX;
				state_d     = stat.photon ? S_M1 : S_OUT;
			end
			S_M1: begin
				cmd.acc_op  = ACC_SQ;
				cmd.mul_sel = MS_YY;
				state_d     = S_M2;
			end
			S_M2: begin
				cmd.acc_op  = ACC_SQ;
				cmd.mul_sel = MS_ZZ;
				state_d     = S_M3;
			end
			S_M3: begin
				cmd.acc_op  = ACC_SQ;
				cmd.mul_sel = MS_XU;
				state_d     = S_M4;
			end
			S_M4: begin
				cmd.acc_op  = ACC_DOT;
				cmd.mul_sel = MS_YU;
				state_d     = S_M5;
			end
			S_M5: begin
				cmd.acc_op  = ACC_DOT;
				cmd.mul_sel = MS_ZU;
				state_d     = S_M6;
			end
			S_M6: begin
				cmd.acc_op       = ACC_DOT;
				cmd.sqrt_init_sq = 1'b1;
				cnt_d            = '0;
				state_d          = S_SQ1;
			end
			S_SQ1: begin
				cmd.sqrt_step = 1'b1;
				cnt_d         = cnt_q + 6'd1;
				if (cnt_q == SQRT_LAST) begin
					cnt_d   = '0;
					state_d = S_DIVI;
				end
			end
			S_DIVI: begin
				cmd.r_latch = 1'b1;
				if (stat.r_zero || stat.dot_nonpos) begin
					ang_sel_d = ANG_90;
					state_d   = S_OUT;
				end else begin
					cmd.div_init = 1'b1;
					cnt_d        = '0;
					state_d      = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 6'd1;
				if (cnt_q == DIV_LAST) begin
					cnt_d   = '0;
					state_d = S_CC;
				end
			end
			S_CC: begin
				cmd.mul_sel = MS_CC;
				if (stat.c_ge_one) begin
					ang_sel_d = ANG_ZERO;
					state_d   = S_OUT;
				end else begin
					state_d = S_SINI;
				end
			end
			S_SINI: begin
				cmd.sqrt_init_sin = 1'b1;
				cnt_d             = '0;
				state_d           = S_SQ2;
			end
			S_SQ2: begin
				cmd.sqrt_step = 1'b1;
				cnt_d         = cnt_q + 6'd1;
				if (cnt_q == SQRT_LAST) begin
					cnt_d   = '0;
					state_d = S_CORI;
				end
			end
			S_CORI: begin
				cmd.cor_init = 1'b1;
				cnt_d        = '0;
				state_d      = S_COR;
			end
			S_COR: begin
				cmd.cor_step = 1'b1;
				cnt_d        = cnt_q + 6'd1;
				if (cnt_q == COR_LAST) begin
					cnt_d     = '0;
					ang_sel_d = ANG_COR;
					state_d   = S_OUT;
				end
			end
			S_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			ang_sel_q   <= ANG_ZERO;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			ang_sel_q <= ang_sel_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	ap_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_EDEP))
		else $error("accepted word did not start a run");
	ap_one_iter: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.sqrt_step, cmd.div_step, cmd.cor_step}))
		else $error("two iterative units stepped at once");
	ap_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && out_stall))
		else $error("output word overwritten while stalled");
	ap_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DIV_LAST)
		else $error("step counter out of range");

endmodule
`default_nettype wire

// ===== sv/psc_dp.sv =====
// Datapath: shared multiplier, sums, square root, divider, CORDIC and output words.
`default_nettype none
module psc_dp
	import psc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output stat_t            stat,
	input  wire logic        is_photon,
	input  wire logic [31:0] pos_x,
	input  wire logic [31:0] pos_y,
	input  wire logic [31:0] pos_z,
	input  wire logic [15:0] dir_x,
	input  wire logic [15:0] dir_y,
	input  wire logic [15:0] dir_z,
	input  wire logic [31:0] kinetic_energy,
	input  wire logic [31:0] particle_weight,
	output logic             record_valid,
	output logic [32:0]      radius,
	output logic [14:0]      crossing_angle,
	output logic [62:0]      photon_energy_sum,
	output logic [62:0]      other_energy_sum
);

	// captured item
	logic               photon_q;
	logic signed [31:0] px_q, py_q, pz_q;
	logic signed [15:0] ux_q, uy_q, uz_q;
	logic [31:0]        ke_q, wt_q;

	// multiplier
	logic signed [32:0] ma, mb;
	logic signed [65:0] prod_q;

	// accumulators
	logic [62:0]        psum_q, osum_q;
	logic [63:0]        sq_q;
	logic signed [49:0] dot_q;
	logic [64:0]        sat_tot;
	logic [62:0]        sat_res;

	// square root
	logic [63:0] sv_q, sres_q, sbit_q;
	logic [63:0] s_trial;
	logic        s_ge;

	// divider
	logic [32:0] r_q;
	logic [33:0] rem_q, nq_q, quot_q;
	logic [63:0] numer;
	logic [33:0] d_trial;
	logic        d_ge;

	// CORDIC
	logic signed [35:0] cx_q, cy_q, cxs, cys;
	logic signed [31:0] ang_q, ang_rnd;
	logic [14:0]        cor_ang;

	always_comb begin
		ma = {1'b0, ke_q};
		mb = {1'b0, wt_q};
		case (cmd.mul_sel)
			MS_EDEP: begin
				ma = {1'b0, ke_q};
				mb = {1'b0, wt_q};
			end
			MS_XX: begin
				ma = {px_q[31], px_q};
				mb = {px_q[31], px_q};
			end
			MS_YY: begin
				ma = {py_q[31], py_q};
				mb = {py_q[31], py_q};
			end
			MS_ZZ: begin
				ma = {pz_q[31], pz_q};
				mb = {pz_q[31], pz_q};
			end
			MS_XU: begin
				ma = {px_q[31], px_q};
				mb = {{17{ux_q[15]}}, ux_q};
			end
			MS_YU: begin
				ma = {py_q[31], py_q};
				mb = {{17{uy_q[15]}}, uy_q};
			end
			MS_ZU: begin
				ma = {pz_q[31], pz_q};
				mb = {{17{uz_q[15]}}, uz_q};
			end
			MS_CC: begin
				ma = {3'b0, quot_q[29:0]};
				mb = {3'b0, quot_q[29:0]};
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	always_ff @(posedge clk)
		prod_q <= ma * mb;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			photon_q <= is_photon;
			px_q     <= pos_x;
			py_q     <= pos_y;
			pz_q     <= pos_z;
			ux_q     <= dir_x;
			uy_q     <= dir_y;
			uz_q     <= dir_z;
			ke_q     <= kinetic_energy;
			wt_q     <= particle_weight;
		end
	end

	// saturating add of energy times weight into the selected sum
	assign sat_tot = {2'b0, (photon_q ? psum_q : osum_q)} + {1'b0, prod_q[63:0]};
	assign sat_res = (sat_tot > {2'b0, SUM_MAX}) ? SUM_MAX : sat_tot[62:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psum_q <= '0;
			osum_q <= '0;
		end else if (cmd.acc_op == ACC_SUMS) begin
			if (photon_q)
				psum_q <= sat_res;
			else
				osum_q <= sat_res;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sq_q  <= '0;
			dot_q <= '0;
		end else begin
			case (cmd.acc_op)
				ACC_SQ:  sq_q  <= sq_q + prod_q[63:0];
				ACC_DOT: dot_q <= dot_q + prod_q[49:0];
				default: ;
			endcase
		end
	end

	// bit-pair square root, one result bit per cycle
	assign s_trial = sres_q + sbit_q;
	assign s_ge    = (sv_q >= s_trial);

	always_ff @(posedge clk) begin
		if (cmd.sqrt_init_sq || cmd.sqrt_init_sin) begin
			sv_q   <= cmd.sqrt_init_sq ? sq_q : (64'h1000_0000_0000_0000 - prod_q[63:0]);
			sres_q <= '0;
			sbit_q <= 64'h4000_0000_0000_0000;
		end else if (cmd.sqrt_step) begin
			if (s_ge) begin
				sv_q   <= sv_q - s_trial;
				sres_q <= (sres_q >> 1) + sbit_q;
			end else begin
				sres_q <= sres_q >> 1;
			end
			sbit_q <= sbit_q >> 2;
		end
	end

	// restoring divider: (dot << 15) / r, 34 quotient bits
	assign numer   = {dot_q[48:0], 15'b0};
	assign d_trial = {rem_q[32:0], nq_q[33]};
	assign d_ge    = (d_trial >= {1'b0, r_q});

	always_ff @(posedge clk) begin
		if (cmd.r_latch)
			r_q <= sres_q[32:0];
		if (cmd.div_init) begin
			rem_q  <= {4'b0, numer[63:34]};
			nq_q   <= numer[33:0];
			quot_q <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= d_ge ? (d_trial - {1'b0, r_q}) : d_trial;
			nq_q   <= {nq_q[32:0], 1'b0};
			quot_q <= {quot_q[32:0], d_ge};
		end
	end

	// CORDIC vectoring, one rotation per cycle
	assign cxs = cx_q >>> cmd.cor_idx;
	assign cys = cy_q >>> cmd.cor_idx;

	always_ff @(posedge clk) begin
		if (cmd.cor_init) begin
			cx_q  <= {6'b0, quot_q[29:0]};
			cy_q  <= {4'b0, sres_q[31:0]};
			ang_q <= '0;
		end else if (cmd.cor_step) begin
			if (cy_q > 36'sd0) begin
				cx_q  <= cx_q + cys;
				cy_q  <= cy_q - cxs;
				ang_q <= ang_q + atan_deg(cmd.cor_idx);
			end else begin
				cx_q  <= cx_q - cys;
				cy_q  <= cy_q + cxs;
				ang_q <= ang_q - atan_deg(cmd.cor_idx);
			end
		end
	end

	assign ang_rnd = (ang_q + 32'sd128) >>> 8;
	always_comb begin
		if (ang_rnd < 32'sd0)
			cor_ang = '0;
		else if (ang_rnd > 32'(ANGLE_MAX))
			cor_ang = ANGLE_MAX;
		else
			cor_ang = ang_rnd[14:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			record_valid      <= photon_q;
			radius            <= photon_q ? r_q : 33'd0;
			photon_energy_sum <= psum_q;
			other_energy_sum  <= osum_q;
			case (cmd.ang_sel)
				ANG_90:  crossing_angle <= photon_q ? ANGLE_MAX : 15'd0;
				ANG_COR: crossing_angle <= photon_q ? cor_ang : 15'd0;
				default: crossing_angle <= 15'd0;
			endcase
		end
	end

	assign stat.photon     = photon_q;
	assign stat.r_zero     = (sres_q == 64'd0);
	assign stat.dot_nonpos = dot_q[49] || (dot_q == 50'sd0);
	assign stat.c_ge_one   = (quot_q[33:30] != 4'd0);

endmodule
`default_nettype wire

// ===== sv/photon_sphere_crossing_scorer_core.sv =====
// Sequence: a non-photon word forms its energy product and adds it to its sum; a photon word
// also runs six multiply-accumulate steps, a 32-step radius root, a check, a 34-step divide,
// a clamp check, an init, a 32-step sine root, an init, 23 CORDIC rotations and the load;
// zero radius or cos <= 0 ends it after the root, a cosine clamped to one after the divide.
// Throughput: one word at a time; the next word is taken the cycle after the result is
// loaded into the output register.
// Reset: arst_n clears both energy sums, the sequencer and the output valid at once.
`default_nettype none
module photon_sphere_crossing_scorer_core
	import psc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input word
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        is_photon,
	input  wire logic [31:0] pos_x,
	input  wire logic [31:0] pos_y,
	input  wire logic [31:0] pos_z,
	input  wire logic [15:0] dir_x,
	input  wire logic [15:0] dir_y,
	input  wire logic [15:0] dir_z,
	input  wire logic [31:0] kinetic_energy,
	input  wire logic [31:0] particle_weight,
	// output word
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             record_valid,
	output logic [32:0]      radius,
	output logic [14:0]      crossing_angle,
	output logic [62:0]      photon_energy_sum,
	output logic [62:0]      other_energy_sum
);

	// command and status between sequencer and datapath
	cmd_t  cmd;
	stat_t stat;

	// Sequencer: walks multiply, root, divide and CORDIC steps, owns the handshakes.
	psc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Datapath: captures the word, keeps the saturating sums, holds the output word.
	psc_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.is_photon         (is_photon),
		.pos_x             (pos_x),
		.pos_y             (pos_y),
		.pos_z             (pos_z),
		.dir_x             (dir_x),
		.dir_y             (dir_y),
		.dir_z             (dir_z),
		.kinetic_energy    (kinetic_energy),
		.particle_weight   (particle_weight),
		.record_valid      (record_valid),
		.radius            (radius),
		.crossing_angle    (crossing_angle),
		.photon_energy_sum (photon_energy_sum),
		.other_energy_sum  (other_energy_sum)
	);

endmodule
`default_nettype wire

// ===== bench/tb_photon_sphere_crossing_scorer_core.sv =====
// Self-checking testbench for the photon sphere crossing scorer core.
`timescale 1ns / 100ps
`default_nettype none
module tb_photon_sphere_crossing_scorer_core
	import psc_pkg::*;
();

	// one input word as driven onto the ports
	typedef struct {
		logic        photon;
		logic [31:0] px, py, pz;
		logic [15:0] ux, uy, uz;
		logic [31:0] ke, wt;
	} particle_t;

	// one scored result word
	typedef struct {
		logic        rec;
		logic [32:0] rad;
		logic [14:0] ang;
		logic [62:0] psum;
		logic [62:0] osum;
		logic        typed;	// directed row with a value read off by hand
	} score_t;

	// directed row: stimulus plus optional hand-typed result
	typedef struct {
		particle_t p;
		logic      has_exp;
		logic [32:0] rad;
		logic [14:0] ang;
	} row_t;

	localparam int  RANDOM_WORDS = 900;
	localparam longint CYCLE_LIMIT = 1000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        is_photon = 1'b0;
	logic [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic [15:0] dir_x = '0, dir_y = '0, dir_z = '0;
	logic [31:0] kinetic_energy = '0, particle_weight = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        record_valid;
	logic [32:0] radius;
	logic [14:0] crossing_angle;
	logic [62:0] photon_energy_sum, other_energy_sum;

	// predictor state: running energy sums
	logic [62:0] pred_photon_sum, pred_other_sum;
	score_t      pending_scores[$];
	int          mismatches = 0;
	longint      cycles = 0;
	int          send_idle_pct = 0, recv_idle_pct = 0;

	photon_sphere_crossing_scorer_core dut (.*);

	always #5 clk = ~clk;

	// timeout guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// ---- predictor helpers ----
	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic logic [62:0] sum_sat(input logic [62:0] a, input logic [63:0] b);
		logic [64:0] t;
		t = {2'b0, a} + {1'b0, b};
		return (t > {2'b0, SUM_MAX}) ? SUM_MAX : t[62:0];
	endfunction

	// atan2(s, c) by CORDIC vectoring, Q7.8 degrees
	function automatic logic [14:0] cordic_angle(input longint c, input longint s);
		longint x, y, acc, xs, ys;
		x = c; y = s; acc = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x += ys; y -= xs; acc += longint'(atan_deg(i[4:0]));
			end else begin
				x -= ys; y += xs; acc -= longint'(atan_deg(i[4:0]));
			end
		end
		acc = (acc + 128) >>> 8;
		if (acc < 0) acc = 0;
		if (acc > longint'(ANGLE_MAX)) acc = longint'(ANGLE_MAX);
		return acc[14:0];
	endfunction

	// score one particle and advance the predicted sums
	function automatic score_t score_particle(input particle_t p);
		score_t r;
		logic [63:0] edep, mag, rr, cq, sq;
		longint px, py, pz, dot, ax, ay, az;
		edep = {32'b0, p.ke} * {32'b0, p.wt};
		r.rec = p.photon;
		r.rad = '0;
		r.ang = '0;
		r.typed = 1'b0;
		if (!p.photon) begin
			pred_other_sum = sum_sat(pred_other_sum, edep);
		end else begin
			pred_photon_sum = sum_sat(pred_photon_sum, edep);
			px = longint'($signed(p.px));
			py = longint'($signed(p.py));
			pz = longint'($signed(p.pz));
			ax = px < 0 ? -px : px;
			ay = py < 0 ? -py : py;
			az = pz < 0 ? -pz : pz;
			mag = ax * ax + ay * ay + az * az;	// wraps mod 2^64 like the datapath sum
			rr = int_sqrt(mag);
			r.rad = rr[32:0];
			dot = px * longint'($signed(p.ux)) + py * longint'($signed(p.uy))
				+ pz * longint'($signed(p.uz));
			if (rr == 0 || dot <= 0) begin
				r.ang = ANGLE_MAX;
			end else begin
				cq = (64'(dot) << 15) / rr;
				if (cq >= (64'd1 << 30)) begin
					r.ang = '0;
				end else begin
					sq = int_sqrt((64'd1 << 60) - cq * cq);
					r.ang = cordic_angle(longint'(cq), longint'(sq));
				end
			end
		end
		r.psum = pred_photon_sum;
		r.osum = pred_other_sum;
		return r;
	endfunction

	// ---- driving ----
	// entered at a falling edge; valid stays up after acceptance until the next word
	// or an idle cycle replaces it
	task automatic send_particle(input particle_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		is_photon <= p.photon;
		pos_x <= p.px; pos_y <= p.py; pos_z <= p.pz;
		dir_x <= p.ux; dir_y <= p.uy; dir_z <= p.uz;
		kinetic_energy <= p.ke; particle_weight <= p.wt;
		pending_scores = {pending_scores, score_particle(p)};
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	function automatic particle_t rand_particle();
		particle_t p;
		int sel;
		p.photon = $urandom_range(99) < 70;
		sel = $urandom_range(9);
		// most positions modest so the radius squared stays exact
		if (sel < 7) begin
			p.px = $signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
			p.py = $signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
			p.pz = $signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
		end else begin
			p.px = $urandom; p.py = $urandom; p.pz = $urandom;
		end
		p.ux = $urandom; p.uy = $urandom; p.uz = $urandom;
		if ($urandom_range(3) == 0) begin
			// radial-ish direction: points along position, often a small angle
			p.ux = {p.px[31], p.px[31:17]};
			p.uy = {p.py[31], p.py[31:17]};
			p.uz = {p.pz[31], p.pz[31:17]};
		end
		case ($urandom_range(4))
			0: begin p.ke = $urandom; p.wt = $urandom; end
			1: begin p.ke = 32'hFFFF_FFFF; p.wt = 32'hFFFF_FFFF; end
			default: begin
				p.ke = $urandom_range(32'h00FF_FFFF);
				p.wt = $urandom_range(32'h0001_FFFF);
			end
		endcase
		return p;
	endfunction

	// ---- checking ----
	always @(posedge clk) begin
		score_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_scores.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: rad=%0d ang=%0d", radius, crossing_angle);
			end else begin
				e = pending_scores.pop_front();
				if (record_valid !== e.rec || radius !== e.rad || crossing_angle !== e.ang
					|| photon_energy_sum !== e.psum || other_energy_sum !== e.osum) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch%s: exp rec=%0d rad=%0d ang=%0d ps=%0h os=%0h",
							e.typed ? " (directed)" : "", e.rec, e.rad, e.ang, e.psum, e.osum,
							"\n          got rec=%0d rad=%0d ang=%0d ps=%0h os=%0h",
							record_valid, radius, crossing_angle,
							photon_energy_sum, other_energy_sum);
				end
			end
		end
	end

	// receiver stall, changed at the falling edge
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_idle_pct);

	// ---- directed table ----
	localparam logic [31:0] ONE_CM = 32'h0001_0000;
	localparam logic [15:0] U_ONE = 16'h7FFF;
	localparam logic [15:0] U_NEG = 16'h8000;
	row_t rows[$];

	task automatic add_row(input logic ph, input logic [31:0] x, y, z,
		input logic [15:0] a, b, c, input logic [31:0] k, w,
		input logic has, input logic [32:0] rad, input logic [14:0] ang);
		row_t r;
		r.p = '{ph, x, y, z, a, b, c, k, w};
		r.has_exp = has; r.rad = rad; r.ang = ang;
		rows = {rows, r};
	endtask

	initial begin
		score_t s;
		particle_t p;
		// zero radius: 90 degrees
		add_row(1, 0, 0, 0, U_ONE, 0, 0, 0, 0, 1, 0, ANGLE_MAX);
		// non-photon: record fields zero
		add_row(0, ONE_CM, 0, 0, U_ONE, 0, 0, ONE_CM, ONE_CM, 1, 0, 0);
		// outward along x: cosine just under one, angle near 0
		add_row(1, ONE_CM, 0, 0, 16'h7FFF, 0, 0, ONE_CM, ONE_CM, 0, 0, 0);
		// inward: dot negative, 90 degrees
		add_row(1, ONE_CM, 0, 0, U_NEG, 0, 0, 1, 1, 1, 33'h1_0000, ANGLE_MAX);
		// tangent: dot zero
		add_row(1, 0, ONE_CM, 0, U_ONE, 0, 0, 1, 1, 1, 33'h1_0000, ANGLE_MAX);
		// extremes of position
		add_row(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, U_NEG, U_NEG, U_NEG,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
		add_row(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, U_ONE, U_ONE, U_ONE,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
		add_row(1, 32'hFFFF_FFFF, 0, 0, U_NEG, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0);
		// 45 degrees and off-unit directions
		add_row(1, ONE_CM, ONE_CM, 0, U_ONE, 0, 0, 5, 7, 0, 0, 0);
		add_row(1, ONE_CM, 0, 0, 16'h4000, 16'h4000, 0, 5, 7, 0, 0, 0);
		add_row(1, ONE_CM, 0, 0, 16'h0100, 16'h0100, 16'h7000, 5, 7, 0, 0, 0);
		add_row(1, 0, 0, 32'hFFF0_0000, 0, 16'hF000, U_NEG, 3, 3, 0, 0, 0);
		// drive both sums into saturation
		for (int i = 0; i < 3; i++) begin
			add_row(0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
			add_row(1, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
		end

		pred_photon_sum = '0;
		pred_other_sum = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 16;
		recv_idle_pct = 45;
		foreach (rows[i]) begin
			send_particle(rows[i].p);
			if (rows[i].has_exp) begin
				s = pending_scores.pop_back();
				s.rad = rows[i].rad;
				s.ang = rows[i].ang;
				s.typed = 1'b1;
				pending_scores = {pending_scores, s};
			end
		end
		// hold off until the block has drained
		in_valid <= 1'b0;
		while (pending_scores.size() != 0) @(negedge clk);

		// the sums are saturated now; restart-free, so pull them no further
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 45 : 0;
			recv_idle_pct = (ph == 0) ? 45 : (ph == 1) ? 16 : 0;
			for (int i = 0; i < RANDOM_WORDS / 3; i++) begin
				p = rand_particle();
				send_particle(p);
			end
		end

		in_valid <= 1'b0;
		while (pending_scores.size() != 0) @(negedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire
